// ===== src/clnws_pkg.sv =====
// shared types and constants for the character lcd nibble write sequencer
// no dependencies; imported by the front, back and top level modules
`timescale 1ns / 1ps

package clnws_pkg;

  // request function codes (input tuser)
  typedef enum logic [1:0] {
    FUNC_CMD    = 2'd0,
    FUNC_DATA   = 2'd1,
    FUNC_INIT   = 2'd2,
    FUNC_CURSOR = 2'd3
  } func_t;

  // work kinds carried from front to back
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_INIT = 1'b1
  } kind_t;

  // one queued job: a two-nibble byte write or the full init sequence
  typedef struct packed {
    kind_t      kind;
    logic       rs;
    logic [7:0] data;
  } job_t;

  // init command bytes held in configuration registers
  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] display_control;
    logic [7:0] entry_mode;
  } init_cfg_t;

  // configuration register indexes
  localparam logic [1:0] REG_FUNCTION_SET    = 2'd0;
  localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd1;
  localparam logic [1:0] REG_ENTRY_MODE      = 2'd2;

  localparam logic [7:0] FUNCTION_SET_RST    = 8'h28;
  localparam logic [7:0] DISPLAY_CONTROL_RST = 8'h0E;
  localparam logic [7:0] ENTRY_MODE_RST      = 8'h06;

  // fixed commands and cursor addressing
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] ROW1_OFFSET    = 8'h40;
  localparam logic [7:0] MAX_COLUMN     = 8'd40;

  // init preamble nibbles and waits
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;
  localparam logic [7:0] WAIT_POWER_UP  = 8'd39;
  localparam logic [7:0] WAIT_WAKE_LONG = 8'd4;
  localparam logic [7:0] WAIT_WAKE_SHORT = 8'd1;
  localparam logic [7:0] WAIT_INIT_CMD  = 8'd249;

  // pulse count of the init sequence and job queue depth
  localparam int INIT_PULSES  = 14;
  localparam int QUEUE_DEPTH  = 4;

endpackage

// ===== src/clnws_front.sv =====
// front end: classifies requests into byte or init jobs and queues them
// depends on clnws_pkg
`timescale 1ns / 1ps

module clnws_front (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // value[7:0], row[8], zero pad
  input  logic [1:0]         in_tuser,   // func[1:0]
  // job queue head
  output logic               q_valid,
  output clnws_pkg::job_t    q_job,
  input  logic               q_pop
);
  import clnws_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  func_t      func;
  logic [7:0] value;
  logic       row;
  job_t       job;
  logic       keep;
  logic       push;

  assign func  = func_t'(in_tuser);
  assign value = in_tdata[7:0];
  assign row   = in_tdata[8];

  // classify the request
  always_comb begin
    job  = '{kind: KIND_BYTE, rs: 1'b0, data: value};
    keep = 1'b1;
    case (func)
      FUNC_CMD:  job.rs = 1'b0;
      FUNC_DATA: job.rs = 1'b1;
      FUNC_INIT: job.kind = KIND_INIT;
      FUNC_CURSOR: begin
        job.data = value | CMD_SET_DDRAM | (row ? ROW1_OFFSET : 8'h00);
        keep     = (value < MAX_COLUMN);
      end
      default: keep = 1'b0;
    endcase
  end

  // queue pointers and fill count
  assign in_tready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (count_r != '0);
  assign q_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job;
    end
  end

endmodule

// ===== src/clnws_back.sv =====
// back end: steps through the pulses of the head job into an output register
// depends on clnws_pkg
`timescale 1ns / 1ps

module clnws_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clnws_pkg::init_cfg_t  cfg,
  // job queue head
  input  logic                  q_valid,
  input  clnws_pkg::job_t       q_job,
  output logic                  q_pop,
  // pulse channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // nibble[3:0], wait_before[11:4],
                                            // high_units[19:12], wait_after[27:20],
                                            // zero pad
  output logic                  out_tuser,  // reg_select[0]
  output logic                  out_tlast
);
  import clnws_pkg::*;

  localparam int STEP_W = 4;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [27:0]       pulse_r;
  logic              rs_r;
  logic              last_r;

  logic              load;
  logic              last_pulse;
  logic [STEP_W-1:0] cmd_idx;
  logic [7:0]        byte_sel;
  logic              rs;
  logic [3:0]        nib;
  logic [7:0]        pre_wait, high, after;

  // pick the byte for the current pulse
  always_comb begin
    cmd_idx  = step_r - STEP_W'(4);
    byte_sel = q_job.data;
    if (q_job.kind == KIND_INIT) begin
      case (cmd_idx[3:1])
        3'd0:    byte_sel = cfg.function_set;
        3'd1:    byte_sel = cfg.display_control;
        3'd2:    byte_sel = CMD_CLEAR;
        3'd3:    byte_sel = cfg.entry_mode;
        default: byte_sel = CMD_SET_DDRAM;
      endcase
    end
  end

  // pulse fields for the current step
  always_comb begin
    rs       = 1'b0;
    nib      = byte_sel[7:4];
    pre_wait = 8'd0;
    high     = 8'd1;
    after    = 8'd0;
    if (q_job.kind == KIND_BYTE) begin
      rs         = q_job.rs;
      last_pulse = (step_r == STEP_W'(1));
      if (step_r[0]) nib = byte_sel[3:0];
    end else begin
      last_pulse = (step_r == STEP_W'(INIT_PULSES - 1));
      case (step_r)
        4'd0: begin
          nib = NIB_WAKE; high = 8'd0; pre_wait = WAIT_POWER_UP; after = WAIT_WAKE_LONG;
        end
        4'd1: begin
          nib = NIB_WAKE; high = 8'd0; after = WAIT_WAKE_LONG;
        end
        4'd2: begin
          nib = NIB_WAKE; high = 8'd0; after = WAIT_WAKE_SHORT;
        end
        4'd3: begin
          nib = NIB_4BIT; high = 8'd0;
        end
        default: begin
          if (cmd_idx[0]) begin
            nib   = byte_sel[3:0];
            after = WAIT_INIT_CMD;
          end
        end
      endcase
    end
  end

  // advance when the output register is free or being drained
  assign load  = q_valid && (!out_valid_r || out_tready);
  assign q_pop = load && last_pulse;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = last_pulse ? '0 : step_r + STEP_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      pulse_r <= {after, high, pre_wait, nib};
      rs_r    <= rs;
      last_r  <= last_pulse;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, pulse_r};
  assign out_tuser  = rs_r;
  assign out_tlast  = last_r;

  // a byte job never goes past its second pulse
  a_byte_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_job.kind == KIND_BYTE) |-> (step_r <= STEP_W'(1)))
    else $error("byte job step out of range");

  // the step counter restarts after the final pulse of a job
  a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (step_r == '0))
    else $error("step counter not cleared after job");

  // the final pulse of a job is flagged last on the output
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_tvalid && out_tlast))
    else $error("job end not marked last");

endmodule

// ===== src/char_lcd_nibble_write_sequencer_core.sv =====
// top level: configuration registers, request front end and pulse back end
// depends on clnws_pkg, clnws_front, clnws_back
// the first pulse of an accepted request passes from the job queue into the back end's output register
// throughput: one pulse beat per cycle while out_tready is high; a byte request gives two pulses and
//   init gives fourteen, stepped by the back end's pulse step counter
// a four-entry job queue lets requests be taken while pulses are still draining
// a cursor move at or beyond column 40 gives no pulses
// reset (rst_n low, synchronous) empties the queue and restores the init bytes
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // value[7:0], row[8], zero pad
  input  logic [1:0]  in_tuser,   // func[1:0]
  // pulse channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // nibble[3:0], wait_before[11:4], high_units[19:12],
                                  // wait_after[27:20], zero pad
  output logic        out_tuser,  // reg_select[0]
  output logic        out_tlast
);
  import clnws_pkg::*;

  init_cfg_t cfg_r, cfg_nxt;
  logic      q_valid;
  job_t      q_job;
  logic      q_pop;

  // configuration registers; unused index is ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FUNCTION_SET:    cfg_nxt.function_set    = cfg_wdata;
        REG_DISPLAY_CONTROL: cfg_nxt.display_control = cfg_wdata;
        REG_ENTRY_MODE:      cfg_nxt.entry_mode      = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{function_set: FUNCTION_SET_RST, display_control: DISPLAY_CONTROL_RST,
                 entry_mode: ENTRY_MODE_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  clnws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop)
  );

  clnws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/sv/tb_char_lcd_nibble_write_sequencer_core.sv =====
// testbench for the character lcd nibble write sequencer core
// drives requests, predicts the enable pulses of each one and checks every out beat
// depends on clnws_pkg and char_lcd_nibble_write_sequencer_core
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer_core;
  import clnws_pkg::*;

  localparam int          CYCLE_LIMIT      = 300000;
  localparam int          SETTLE_CYCLES    = 16;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          RANDOM_PER_PHASE = 110;
  localparam int          N_DIRECTED       = 18;
  localparam int          MAX_REPORTS      = 40;
  localparam logic [1:0]  REG_UNUSED       = 2'd3;
  localparam logic [7:0]  CLEAR_DISPLAY    = 8'h01;
  localparam logic [7:0]  SET_ADDRESS      = 8'h80;
  localparam logic [7:0]  SECOND_ROW       = 8'h40;
  localparam logic [7:0]  COLUMN_LIMIT     = 8'd40;

  // one enable pulse as seen on the out channel
  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic [7:0] wait_pre;
    logic [7:0] high_units;
    logic [7:0] wait_post;
    logic       last;
  } pulse_t;

  // directed request; typed rows carry their own pulse count and byte
  typedef struct packed {
    func_t      func;
    logic [7:0] value;
    logic       row;
    logic       typed;
    logic [1:0] n_pulses;
    logic       rs;
    logic [7:0] cmd_byte;
  } req_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // predictor copy of the init command bytes
  logic [7:0]  fs_byte = 8'h28;
  logic [7:0]  dc_byte = 8'h0E;
  logic [7:0]  em_byte = 8'h06;

  pulse_t      pending_pulses[$];
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned pattern_left  = 0;
  int unsigned stall_pct     = 0;

  req_row_t directed_reqs [0:N_DIRECTED-1] = '{
    '{FUNC_INIT,   8'h00, 1'b0, 1'b0, 2'd0, 1'b0, 8'h00},
    '{FUNC_CMD,    8'h00, 1'b0, 1'b1, 2'd2, 1'b0, 8'h00},
    '{FUNC_CMD,    8'hFF, 1'b1, 1'b1, 2'd2, 1'b0, 8'hFF},
    '{FUNC_DATA,   8'h00, 1'b1, 1'b1, 2'd2, 1'b1, 8'h00},
    '{FUNC_DATA,   8'hFF, 1'b0, 1'b1, 2'd2, 1'b1, 8'hFF},
    '{FUNC_DATA,   8'hA5, 1'b1, 1'b0, 2'd0, 1'b0, 8'h00},
    '{FUNC_CMD,    8'h5A, 1'b0, 1'b0, 2'd0, 1'b0, 8'h00},
    '{FUNC_CURSOR, 8'd0,  1'b0, 1'b1, 2'd2, 1'b0, 8'h80},
    '{FUNC_CURSOR, 8'd39, 1'b1, 1'b1, 2'd2, 1'b0, 8'hE7},
    '{FUNC_CURSOR, 8'd40, 1'b0, 1'b1, 2'd0, 1'b0, 8'h00},
    '{FUNC_CURSOR, 8'hFF, 1'b1, 1'b1, 2'd0, 1'b0, 8'h00},
    '{FUNC_CURSOR, 8'd39, 1'b0, 1'b1, 2'd2, 1'b0, 8'hA7},
    '{FUNC_CURSOR, 8'd0,  1'b1, 1'b1, 2'd2, 1'b0, 8'hC0},
    '{FUNC_CURSOR, 8'h80, 1'b0, 1'b1, 2'd0, 1'b0, 8'h00},
    '{FUNC_CURSOR, 8'd40, 1'b1, 1'b1, 2'd0, 1'b0, 8'h00},
    '{FUNC_DATA,   8'h3C, 1'b0, 1'b0, 2'd0, 1'b0, 8'h00},
    '{FUNC_INIT,   8'hFF, 1'b1, 1'b0, 2'd0, 1'b0, 8'h00},
    '{FUNC_CURSOR, 8'd19, 1'b1, 1'b0, 2'd0, 1'b0, 8'h00}
  };

  char_lcd_nibble_write_sequencer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value[7:0], row[8], zero pad
    .in_tuser   (in_tuser),   // func[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // nibble[3:0], wait_before[11:4], high_units[19:12],
                              // wait_after[27:20], zero pad
    .out_tuser  (out_tuser),  // reg_select[0]
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected pulse store
  function automatic void push_pulse(logic rs, logic [3:0] nib, logic [7:0] pre,
                                     logic [7:0] high, logic [7:0] post, logic last);
    pulse_t p;
    p = '{rs, nib, pre, high, post, last};
    pending_pulses.push_back(p);
  endfunction

  // two-nibble write, high half first
  function automatic void push_byte(logic rs, logic [7:0] b, logic [7:0] post, logic last);
    push_pulse(rs, b[7:4], 8'd0, 8'd1, 8'd0, 1'b0);
    push_pulse(rs, b[3:0], 8'd0, 8'd1, post, last);
  endfunction

  // pulses that one request turns into
  function automatic void plan_pulses(func_t f, logic [7:0] v, logic r);
    case (f)
      FUNC_CMD: begin
        push_byte(1'b0, v, 8'd0, 1'b1);
      end
      FUNC_DATA: begin
        push_byte(1'b1, v, 8'd0, 1'b1);
      end
      FUNC_INIT: begin
        push_pulse(1'b0, 4'h3, 8'd39, 8'd0, 8'd4, 1'b0);
        push_pulse(1'b0, 4'h3, 8'd0,  8'd0, 8'd4, 1'b0);
        push_pulse(1'b0, 4'h3, 8'd0,  8'd0, 8'd1, 1'b0);
        push_pulse(1'b0, 4'h2, 8'd0,  8'd0, 8'd0, 1'b0);
        push_byte(1'b0, fs_byte,       8'd249, 1'b0);
        push_byte(1'b0, dc_byte,       8'd249, 1'b0);
        push_byte(1'b0, CLEAR_DISPLAY, 8'd249, 1'b0);
        push_byte(1'b0, em_byte,       8'd249, 1'b0);
        push_byte(1'b0, SET_ADDRESS,   8'd249, 1'b1);
      end
      default: begin
        // cursor move; out of range columns give nothing
        if (v < COLUMN_LIMIT)
          push_byte(1'b0, v | SET_ADDRESS | (r ? SECOND_ROW : 8'h00), 8'd0, 1'b1);
      end
    endcase
  endfunction

  // one request beat, with bursts and gaps on the sender side
  task automatic send_req(func_t f, logic [7:0] v, logic r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {7'd0, r, v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // sender pause until every pulse is out, then let the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; caller lowers cfg_we after the last one
  task automatic write_reg(logic [1:0] idx, logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    case (idx)
      REG_FUNCTION_SET:    fs_byte = d;
      REG_DISPLAY_CONTROL: dc_byte = d;
      REG_ENTRY_MODE:      em_byte = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // receiver: random stall pattern, stretches with no stalls, and a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2:    stall_pct = 25;
          3:    stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // out beat checker
  always @(posedge clk) begin : pulse_monitor
    pulse_t got;
    pulse_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[3:0], out_tdata[11:4], out_tdata[19:12],
              out_tdata[27:20], out_tlast};
      if (pending_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, actual %p", $time, got);
      end else begin
        want = pending_pulses.pop_front();
        check_field("reg_select",  want.rs,         got.rs);
        check_field("nibble",      want.nibble,     got.nibble);
        check_field("wait_before", want.wait_pre,   got.wait_pre);
        check_field("high_units",  want.high_units, got.high_units);
        check_field("wait_after",  want.wait_post,  got.wait_post);
        check_field("last",        want.last,       got.last);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("** char_lcd_nibble_write_sequencer_core: FAILED **");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    req_row_t    r;
    func_t       f;
    logic [7:0]  v;
    logic        rw;
    int unsigned pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at reset settings
    for (int i = 0; i < N_DIRECTED; i++) begin
      r = directed_reqs[i];
      send_req(r.func, r.value, r.row);
      if (r.typed) begin
        if (r.n_pulses != 0)
          push_byte(r.rs, r.cmd_byte, 8'd0, 1'b1);
      end else begin
        plan_pulses(r.func, r.value, r.row);
      end
    end

    // random phases, each under its own init settings
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_reg(REG_FUNCTION_SET,    8'h00);
          write_reg(REG_DISPLAY_CONTROL, 8'h00);
          write_reg(REG_ENTRY_MODE,      8'h00);
          write_reg(REG_UNUSED,          8'hFF);
        end
        1: begin
          write_reg(REG_FUNCTION_SET,    8'hFF);
          write_reg(REG_DISPLAY_CONTROL, 8'hFF);
          write_reg(REG_ENTRY_MODE,      8'hFF);
          write_reg(REG_UNUSED,          8'h00);
        end
        2: begin
          write_reg(REG_UNUSED,          8'($urandom));
          write_reg(REG_ENTRY_MODE,      8'($urandom));
          write_reg(REG_FUNCTION_SET,    8'($urandom));
          write_reg(REG_DISPLAY_CONTROL, 8'($urandom));
        end
        default: begin
          write_reg(REG_FUNCTION_SET,    8'h28);
          write_reg(REG_DISPLAY_CONTROL, 8'h0E);
          write_reg(REG_ENTRY_MODE,      8'h06);
        end
      endcase
      cfg_we <= 1'b0;
      // receiver holds off while the sender keeps pushing
      if (phase == 1)
        hold_req++;

      // lead with init so the new command bytes show up
      send_req(FUNC_INIT, 8'($urandom), 1'($urandom));
      plan_pulses(FUNC_INIT, 8'h00, 1'b0);

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        v    = 8'($urandom);
        rw   = 1'($urandom);
        if (pick < 30)
          f = FUNC_CMD;
        else if (pick < 55)
          f = FUNC_DATA;
        else if (pick < 68)
          f = FUNC_INIT;
        else begin
          f = FUNC_CURSOR;
          case ($urandom_range(0, 5))
            0:       v = 8'($urandom_range(40, 255));
            1:       v = ($urandom_range(0, 1) == 0) ? 8'd39 : 8'd40;
            default: v = 8'($urandom_range(0, 39));
          endcase
        end
        send_req(f, v, rw);
        plan_pulses(f, v, rw);
      end
    end

    wait_drained();
    if (mismatches == 0)
      $display("** char_lcd_nibble_write_sequencer_core: PASSED **");
    else
      $display("** char_lcd_nibble_write_sequencer_core: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/clnws_pkg.sv
src/clnws_front.sv
src/clnws_back.sv
src/char_lcd_nibble_write_sequencer_core.sv
tb/sv/tb_char_lcd_nibble_write_sequencer_core.sv
